@@ design/go_to_goal_p_controller_core_defines.svh @@
// -----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Shared property wrappers for the checker of the go-to-goal controller.
// -----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_P_CONTROLLER_CORE_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GGPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("go-to-goal controller check failed");

// Next-cycle implication, checked outside reset.
`define GGPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("go-to-goal controller check failed");

`endif

@@ design/ggpc_pkg.sv @@
// -----------------------------------------------------------------------------
// Go-to-goal controller package
// Widths, constants, CORDIC angle table and rounding helpers.
// -----------------------------------------------------------------------------
package ggpc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = 5;

    // CORDIC vector width and angle width (29 fraction bits).
    localparam int CW = 36;
    localparam int AW = 34;

    // Shared multiplier operand widths.
    localparam int MA_W = 34;
    localparam int MB_W = 31;
    localparam int MP_W = MA_W + MB_W;

    localparam logic signed [AW-1:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic [29:0]          INV_GAIN    = 30'd652032875;

    localparam logic [7:0] LIN_GAIN_RST = 8'd32;
    localparam logic [7:0] ANG_GAIN_RST = 8'd32;
    localparam logic [7:0] GOAL_TOL_RST = 8'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LIN_GAIN = 2'd0;
    localparam logic [1:0] REG_ANG_GAIN = 2'd1;
    localparam logic [1:0] REG_GOAL_TOL = 2'd2;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctl;

    function automatic logic signed [AW-1:0] f_atan(input logic [STEP_W-1:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd421657428;
            5'd1:    v = 34'sd248918915;
            5'd2:    v = 34'sd131521918;
            5'd3:    v = 34'sd66762579;
            5'd4:    v = 34'sd33510843;
            5'd5:    v = 34'sd16771758;
            5'd6:    v = 34'sd8387925;
            5'd7:    v = 34'sd4194219;
            5'd8:    v = 34'sd2097141;
            5'd9:    v = 34'sd1048575;
            5'd10:   v = 34'sd524288;
            5'd11:   v = 34'sd262144;
            5'd12:   v = 34'sd131072;
            5'd13:   v = 34'sd65536;
            5'd14:   v = 34'sd32768;
            5'd15:   v = 34'sd16384;
            5'd16:   v = 34'sd8192;
            5'd17:   v = 34'sd4096;
            5'd18:   v = 34'sd2048;
            5'd19:   v = 34'sd1024;
            5'd20:   v = 34'sd512;
            5'd21:   v = 34'sd256;
            5'd22:   v = 34'sd128;
            5'd23:   v = 34'sd64;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round to nearest, ties toward +inf, then saturate to 16 bits.
    function automatic logic [15:0] f_round_sat(input logic signed [MP_W-1:0] v,
                                                input int sh);
        logic signed [MP_W-1:0] t;
        t = (v + (MP_W'(1) <<< (sh - 1))) >>> sh;
        if (t > MP_W'(32767))
            return 16'h7FFF;
        else if (t < -MP_W'(32768))
            return 16'h8000;
        else
            return t[15:0];
    endfunction

endpackage

@@ design/ggpc_cordic.sv @@
// -----------------------------------------------------------------------------
// Go-to-goal CORDIC unit
// One shift-add stage reused for every iteration, rotation or vectoring mode.
// -----------------------------------------------------------------------------
module ggpc_cordic import ggpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_ctl          i_ctl,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [AW-1:0] i_z,
    output logic                 o_done,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [AW-1:0] o_z
);

    logic                 r_busy, r_vec, r_done;
    logic [STEP_W-1:0]    r_step;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;

    logic signed [CW-1:0] xs, ys;
    logic signed [AW-1:0] ang;
    logic                 sel;

    always_comb begin
        xs  = r_x >>> r_step;
        ys  = r_y >>> r_step;
        ang = f_atan(r_step);
        // Rotation follows the residual angle; vectoring drives y toward zero.
        sel = r_vec ? !(r_y > 0) : (r_z >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
            r_vec  <= i_ctl.vectoring;
            r_step <= '0;
        end else if (r_busy) begin
            if (sel) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
            r_step <= r_step + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

@@ design/go_to_goal_p_controller_core.sv @@
// Sequence: a pose update is stored and gives no result. A move request goes to the
// output at once without a pose, or after the distance check once the goal is reached;
// a command then rotates by CORDIC, applies the linear gain, vectors by CORDIC unless
// that gain or the vector is zero, and the turn gain; CORDIC iterates once a cycle.
// Throughput: one item at a time; the next is taken once the sequencer is idle.
// Reset: synchronous, active low; clears the pose and restores the gains.
// -----------------------------------------------------------------------------
// Go-to-goal proportional controller
// Stores the robot pose and turns goal requests into speed and turn commands.
// -----------------------------------------------------------------------------
module go_to_goal_p_controller_core import ggpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_theta,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_no_pose,
    output logic               o_reached,
    output logic               o_command_valid,
    output logic signed [15:0] o_linear_speed,
    output logic signed [15:0] o_turn_rate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SQX   = 14'b00000000000010,
        S_SQY   = 14'b00000000000100,
        S_CMP   = 14'b00000000001000,
        S_SCX   = 14'b00000000010000,
        S_SCY   = 14'b00000000100000,
        S_FOLD  = 14'b00000001000000,
        S_ROT   = 14'b00000010000000,
        S_LIN   = 14'b00000100000000,
        S_VINIT = 14'b00001000000000,
        S_VEC   = 14'b00010000000000,
        S_TURN  = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]         r_lin_gain, r_ang_gain, r_goal_tol;
    logic signed [15:0] r_robot_x, r_robot_y, r_heading;
    logic               r_pose_known;

    logic signed [16:0]     r_dx, r_dy;
    logic [33:0]            r_acc;
    logic signed [MP_W-1:0] r_prod;
    logic signed [CW-1:0]   r_vx, r_vy;
    logic signed [AW-1:0]   r_ang;
    logic [15:0]            r_lin, r_turn;
    logic                   r_pn_no_pose, r_pn_reached, r_pn_cmd;

    logic                   r_o_valid, r_o_no_pose, r_o_reached, r_o_cmd;
    logic [15:0]            r_o_lin, r_o_turn;

    logic                   in_xfer, cfg_wr;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [15:0]            tol_sq;
    logic [33:0]            dist_sq;
    logic signed [CW-1:0]   sc_vy, fold_x, fold_y, vin_x, vin_y;
    logic signed [AW-1:0]   z_head, fold_z, vin_z;
    t_cordic_ctl            cctl;
    logic                   c_done;
    logic signed [CW-1:0]   c_x, c_y;
    logic signed [AW-1:0]   c_z;

    assign o_ready = (r_state == S_IDLE);
    assign in_xfer = i_valid && o_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= LIN_GAIN_RST;
            r_ang_gain <= ANG_GAIN_RST;
            r_goal_tol <= GOAL_TOL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LIN_GAIN: r_lin_gain <= pwdata[7:0];
                REG_ANG_GAIN: r_ang_gain <= pwdata[7:0];
                REG_GOAL_TOL: r_goal_tol <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LIN_GAIN: prdata = {24'd0, r_lin_gain};
            REG_ANG_GAIN: prdata = {24'd0, r_ang_gain};
            REG_GOAL_TOL: prdata = {24'd0, r_goal_tol};
            default:      prdata = '0;
        endcase
    end

    // Shared multiplier operand selection
    always_comb begin
        case (r_state)
            S_SQX:   begin mul_a = MA_W'(r_dx);     mul_b = MB_W'(r_dx); end
            S_SQY:   begin mul_a = MA_W'(r_dy);     mul_b = MB_W'(r_dy); end
            S_SCX:   begin mul_a = MA_W'(r_dx);     mul_b = {1'b0, INV_GAIN}; end
            S_SCY:   begin mul_a = MA_W'(r_dy);     mul_b = {1'b0, INV_GAIN}; end
            S_LIN:   begin mul_a = r_vx[MA_W-1:0];  mul_b = MB_W'({1'b0, r_lin_gain}); end
            S_TURN:  begin mul_a = r_ang;           mul_b = MB_W'({1'b0, r_ang_gain}); end
            default: begin mul_a = '0;              mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MP_W'(mul_a) * MP_W'(mul_b);
    end

    always_comb begin
        tol_sq  = 16'(r_goal_tol) * 16'(r_goal_tol);
        dist_sq = r_acc + r_prod[33:0];
        sc_vy   = CW'(r_prod >>> 14);

        // Heading enters as -theta with 29 fraction bits, folded into half-pi.
        z_head = -{{2{r_heading[15]}}, r_heading, 16'd0};
        if (z_head > ANG_HALF_PI) begin
            fold_x = -r_vx;
            fold_y = -sc_vy;
            fold_z = z_head - ANG_PI;
        end else if (z_head < -ANG_HALF_PI) begin
            fold_x = -r_vx;
            fold_y = -sc_vy;
            fold_z = z_head + ANG_PI;
        end else begin
            fold_x = r_vx;
            fold_y = sc_vy;
            fold_z = z_head;
        end

        // A vector in the left half-plane is mirrored and the angle offset by pi.
        if (r_vx < 0) begin
            vin_x = -r_vx;
            vin_y = -r_vy;
            vin_z = (r_vy >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            vin_x = r_vx;
            vin_y = r_vy;
            vin_z = '0;
        end

        cctl.start     = 1'b0;
        cctl.vectoring = 1'b0;
        if (r_state == S_FOLD) begin
            cctl.start = 1'b1;
        end else if (r_state == S_VINIT && r_lin_gain != 8'd0 &&
                     !(r_vx == 0 && r_vy == 0)) begin
            cctl.start     = 1'b1;
            cctl.vectoring = 1'b1;
        end
    end

    ggpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cctl),
        .i_x     (r_state == S_FOLD ? fold_x : vin_x),
        .i_y     (r_state == S_FOLD ? fold_y : vin_y),
        .i_z     (r_state == S_FOLD ? fold_z : vin_z),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer && i_kind) n_state = r_pose_known ? S_SQX : S_OUT;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_CMP;
            S_CMP:   n_state = (dist_sq <= 34'(tol_sq)) ? S_OUT : S_SCX;
            S_SCX:   n_state = S_SCY;
            S_SCY:   n_state = S_FOLD;
            S_FOLD:  n_state = S_ROT;
            S_ROT:   if (c_done) n_state = S_LIN;
            S_LIN:   n_state = S_VINIT;
            S_VINIT: n_state = cctl.start ? S_VEC : S_TURN;
            S_VEC:   if (c_done) n_state = S_TURN;
            S_TURN:  n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!r_o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pose_known <= 1'b0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_heading    <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer && !i_kind) begin
                r_robot_x    <= i_pose_x;
                r_robot_y    <= i_pose_y;
                r_heading    <= i_pose_theta;
                r_pose_known <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dx         <= 17'(i_goal_x) - 17'(r_robot_x);
                r_dy         <= 17'(i_goal_y) - 17'(r_robot_y);
                r_pn_no_pose <= 1'b1;
                r_pn_reached <= 1'b0;
                r_pn_cmd     <= 1'b0;
                r_lin        <= '0;
                r_turn       <= '0;
            end
            S_SQY:   r_acc <= r_prod[33:0];
            S_CMP: begin
                r_pn_no_pose <= 1'b0;
                r_pn_reached <= 1'b1;
            end
            S_SCY:   r_vx <= CW'(r_prod >>> 14);
            S_ROT: begin
                if (c_done) begin
                    r_vx <= c_x;
                    r_vy <= c_y;
                end
            end
            S_VINIT: begin
                r_lin <= f_round_sat(r_prod, 20);
                r_ang <= '0;
            end
            S_VEC:   if (c_done) r_ang <= c_z;
            S_FIN: begin
                r_turn       <= f_round_sat(r_prod, 21);
                r_pn_reached <= 1'b0;
                r_pn_cmd     <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_o_valid || i_ready)) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_o_valid || i_ready)) begin
            r_o_no_pose <= r_pn_no_pose;
            r_o_reached <= r_pn_reached;
            r_o_cmd     <= r_pn_cmd;
            r_o_lin     <= r_lin;
            r_o_turn    <= r_turn;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_no_pose       = r_o_no_pose;
    assign o_reached       = r_o_reached;
    assign o_command_valid = r_o_cmd;
    assign o_linear_speed  = r_o_lin;
    assign o_turn_rate     = r_o_turn;

endmodule

@@ design/ggpc_checker.sv @@
// -----------------------------------------------------------------------------
// Go-to-goal controller checker
// Port-level checks on result transfers and the busy window of a request.
// -----------------------------------------------------------------------------
`include "go_to_goal_p_controller_core_defines.svh"

module ggpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_kind,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_no_pose,
    input logic               o_reached,
    input logic               o_command_valid,
    input logic signed [15:0] o_linear_speed,
    input logic signed [15:0] o_turn_rate
);

    `GGPC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `GGPC_ASSERT_NOW(a_one_flag, o_valid, $onehot({o_no_pose, o_reached, o_command_valid}))
    `GGPC_ASSERT_NOW(a_zero_cmd, o_valid && !o_command_valid, o_linear_speed == 16'sd0 && o_turn_rate == 16'sd0)
    `GGPC_ASSERT_NEXT(a_req_busy, i_valid && o_ready && i_kind, !o_ready)

endmodule

bind go_to_goal_p_controller_core ggpc_checker u_ggpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_kind          (i_kind),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_no_pose       (o_no_pose),
    .o_reached       (o_reached),
    .o_command_valid (o_command_valid),
    .o_linear_speed  (o_linear_speed),
    .o_turn_rate     (o_turn_rate)
);
